// ===== rtl/cpdg_pkg.sv =====
// Shared types and constants for the cell pulse decay grid.
// No dependencies.
`default_nettype none

package cpdg_pkg;

    localparam int OP_W    = 2;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 5;
    localparam int SIZE_W  = 16;
    localparam int TIMER_W = 16;
    localparam int DECAY_W = 15;
    localparam int FRAC_W  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_EN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_ONE = 16'h8000;

    typedef struct packed {
        logic               cued;
        logic [TIMER_W-1:0] timer;
        logic [SIZE_W-1:0]  size;
    } t_cell;

endpackage

`default_nettype wire

// ===== rtl/cell_pulse_decay_grid.sv =====
// Cell pulse decay grid: per-cell size, timer and cue kept in one RAM.
// Query result: registered from the RAM read data in the query state, once the result register is free.
// Items: no new item is taken until the last one is done; a tick walks one cell per
// cycle (one read and one write port), a disabled tick walks no cells; a query holds while a result stalls.
// Reset: synchronous; afterwards a clearing pass walks every address and
// loads every cell before the first item is taken. Config writes always taken.
`default_nettype none

module cell_pulse_decay_grid
    import cpdg_pkg::*;
#(
    parameter int ROWS = 15,
    parameter int COLS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [ROW_W-1:0]      i_row,
    input  wire logic [COL_W-1:0]      i_col,
    input  wire logic [TIMER_W-1:0]    i_delay,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_visible,
    output logic [SIZE_W-1:0]          o_cell_size_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NCELLS = (ROWS + 1) * (COLS + 1);
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NCELLS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PULSE,
        ST_QUERY,
        ST_TICK
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_addr;
    logic                 r_inrange;
    logic [TIMER_W-1:0]   r_delay;
    logic                 r_pulse_en;
    logic                 r_transform_en;
    logic [DECAY_W-1:0]   r_decay;
    logic [SIZE_W-1:0]    r_threshold;
    logic                 r_out_valid;
    logic                 r_visible;
    logic [SIZE_W-1:0]    r_size_out;

    t_cell                r_mem [NCELLS];
    t_cell                r_rd_data;

    logic                 w_in_acc;
    logic                 w_inrange;
    logic [AW-1:0]        w_idx;
    logic                 w_out_free;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    t_cell                w_wdata;
    logic [AW-1:0]        w_raddr;
    t_cell                w_tick_cell;
    logic [SIZE_W+DECAY_W-1:0] w_prod;
    logic [TIMER_W-1:0]   w_timer_dec;

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_visible       = r_visible;
    assign o_cell_size_out = r_size_out;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_inrange  = (int'(i_row) <= ROWS) && (int'(i_col) <= COLS);
    assign w_idx      = AW'(int'(i_row) * (COLS + 1) + int'(i_col));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // tick update of one cell
    always_comb begin
        w_prod      = (SIZE_W+DECAY_W)'(r_rd_data.size) * (SIZE_W+DECAY_W)'(r_decay);
        w_timer_dec = (r_rd_data.timer != '0) ? r_rd_data.timer - 1'b1 : r_rd_data.timer;
        w_tick_cell = r_rd_data;
        if (r_transform_en && (r_rd_data.size != '0)) begin
            w_tick_cell.size = w_prod[FRAC_W +: SIZE_W];
        end
        w_tick_cell.timer = w_timer_dec;
        if (r_rd_data.cued && (w_timer_dec == '0)) begin
            w_tick_cell.size = SIZE_ONE;
            w_tick_cell.cued = 1'b0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_tick_cell;
        w_raddr = r_addr;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '{cued: 1'b0, timer: '0, size: SIZE_ONE};
            end
            ST_IDLE: begin
                w_raddr = (i_operation == OP_TICK) ? '0 : w_idx;
            end
            ST_PULSE: begin
                w_we    = 1'b1;
                w_wdata = '{cued: 1'b1, timer: r_delay, size: r_rd_data.size};
            end
            ST_QUERY: begin
                w_raddr = r_addr;
            end
            ST_TICK: begin
                w_we    = 1'b1;
                w_raddr = r_addr + 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_addr         <= '0;
            r_out_valid    <= 1'b0;
            r_pulse_en     <= 1'b0;
            r_transform_en <= 1'b0;
            r_decay        <= '0;
            r_threshold    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_PULSE_EN:     r_pulse_en     <= i_cfg_data[0];
                    CFG_TRANSFORM_EN: r_transform_en <= i_cfg_data[0];
                    CFG_DECAY:        r_decay        <= i_cfg_data[DECAY_W-1:0];
                    CFG_THRESHOLD:    r_threshold    <= i_cfg_data;
                    default:          r_decay        <= r_decay;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != ST_QUERY)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_addr    <= (i_operation == OP_TICK) ? '0 : w_idx;
                        r_inrange <= w_inrange;
                        r_delay   <= i_delay;
                        case (i_operation)
                            OP_PULSE: begin
                                if (w_inrange) begin
                                    r_state <= ST_PULSE;
                                end
                            end
                            OP_TICK: begin
                                if (r_pulse_en) begin
                                    r_state <= ST_TICK;
                                end
                            end
                            OP_QUERY: begin
                                r_state <= ST_QUERY;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PULSE: begin
                    r_state <= ST_IDLE;
                end
                ST_QUERY: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_visible   <= r_inrange && (r_rd_data.size > r_threshold);
                        r_size_out  <= r_inrange ? r_rd_data.size : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_TICK: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_in_stall)
        else $error("item accepted during clearing pass");

    a_range_query_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QUERY && !r_inrange && w_out_free)
        |=> (o_out_valid && !o_visible && o_cell_size_out == '0))
        else $error("out-of-range query returned nonzero result");

    a_visible_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_visible) |-> (o_cell_size_out > r_threshold))
        else $error("visible flag disagrees with size and threshold");

    a_tick_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> (r_addr <= LAST_ADDR))
        else $error("tick walk address out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/grid_query_checker.sv =====
// Checker for the cell pulse decay grid: watches the item, result and register channels,
// keeps its own copy of the grid and registers, and compares each query result.
// Depends on cpdg_pkg for widths, operation codes and register indexes.
module grid_query_checker
    import cpdg_pkg::*;
#(
    parameter int ROWS = 15,
    parameter int COLS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [ROW_W-1:0]      i_row,
    input  wire logic [COL_W-1:0]      i_col,
    input  wire logic [TIMER_W-1:0]    i_delay,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_visible,
    input  wire logic [SIZE_W-1:0]     i_cell_size_out,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    localparam int NCELLS = (ROWS + 1) * (COLS + 1);

    typedef struct packed {
        logic              visible;
        logic [SIZE_W-1:0] size;
    } t_read;

    logic [SIZE_W-1:0]  size_mem  [NCELLS];
    logic [TIMER_W-1:0] timer_mem [NCELLS];
    logic               cued_mem  [NCELLS];

    logic               pulse_en;
    logic               transform_en;
    logic [DECAY_W-1:0] decay;
    logic [SIZE_W-1:0]  threshold;

    t_read pending_reads[$];
    int    fails = 0;

    task automatic grid_reset();
        pulse_en     = 1'b0;
        transform_en = 1'b0;
        decay        = '0;
        threshold    = '0;
        for (int i = 0; i < NCELLS; i++) begin
            size_mem[i]  = SIZE_ONE;
            timer_mem[i] = '0;
            cued_mem[i]  = 1'b0;
        end
    endtask

    task automatic grid_tick();
        logic [SIZE_W+DECAY_W-1:0] prod;
        if (!pulse_en)
            return;
        for (int i = 0; i < NCELLS; i++) begin
            if (transform_en && size_mem[i] != 0) begin
                prod = size_mem[i] * decay;
                size_mem[i] = prod[SIZE_W+DECAY_W-1:FRAC_W];
            end
            if (timer_mem[i] != 0)
                timer_mem[i] = timer_mem[i] - 1'b1;
            if (cued_mem[i] && timer_mem[i] == 0) begin
                size_mem[i] = SIZE_ONE;
                cued_mem[i] = 1'b0;
            end
        end
    endtask

    function automatic int cell_index(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        if (int'(row) > ROWS || int'(col) > COLS)
            return -1;
        return int'(row) * (COLS + 1) + int'(col);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_read got;
        t_read want;
        int    idx;
        if (!i_rst_n) begin
            grid_reset();
            pending_reads.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PULSE_EN:     pulse_en     = i_cfg_data[0];
                    CFG_TRANSFORM_EN: transform_en = i_cfg_data[0];
                    CFG_DECAY:        decay        = i_cfg_data[DECAY_W-1:0];
                    CFG_THRESHOLD:    threshold    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.visible = i_visible;
                got.size    = i_cell_size_out;
                if (pending_reads.size() == 0) begin
                    fails++;
                    $display("%0t: result with no query pending: visible %0d size %0d",
                             $time, got.visible, got.size);
                end else begin
                    want = pending_reads.pop_front();
                    if (got.visible !== want.visible) begin
                        fails++;
                        $display("%0t: visible mismatch: expected %0d actual %0d",
                                 $time, want.visible, got.visible);
                    end
                    if (got.size !== want.size) begin
                        fails++;
                        $display("%0t: cell_size_out mismatch: expected %0d actual %0d",
                                 $time, want.size, got.size);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                idx = cell_index(i_row, i_col);
                case (i_operation)
                    OP_PULSE: begin
                        if (idx >= 0) begin
                            cued_mem[idx]  = 1'b1;
                            timer_mem[idx] = i_delay;
                        end
                    end
                    OP_TICK: grid_tick();
                    OP_QUERY: begin
                        want = '0;
                        if (idx >= 0) begin
                            want.visible = size_mem[idx] > threshold;
                            want.size    = size_mem[idx];
                        end
                        pending_reads.insert(pending_reads.size(), want);
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_reads.size();
    end
endmodule

// ===== bench/cell_pulse_decay_grid_tb.sv =====
// Testbench top for cell_pulse_decay_grid: drives items and register writes under
// several idle/stall mixes and prints the verdict from grid_query_checker.
// Depends on cpdg_pkg, cell_pulse_decay_grid and grid_query_checker.
module cell_pulse_decay_grid_tb;
    import cpdg_pkg::*;

    localparam int LIMIT       = 2_000_000;
    localparam int DRAIN       = 600;
    localparam int PHASE_ITEMS = 195;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_operation = OP_PULSE;
    logic [ROW_W-1:0]      i_row = '0;
    logic [COL_W-1:0]      i_col = '0;
    logic [TIMER_W-1:0]    i_delay = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_visible;
    logic [SIZE_W-1:0]     o_cell_size_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    cell_pulse_decay_grid DUT (.*);

    grid_query_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_operation, .i_row,
        .i_col, .i_delay, .i_out_valid(o_out_valid), .i_out_stall, .i_visible(o_visible),
        .i_cell_size_out(o_cell_size_out), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [TIMER_W-1:0] delay);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_row       <= row;
        i_col       <= col;
        i_delay     <= delay;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] pe, input logic [CFG_DATA_W-1:0] te,
                                input logic [CFG_DATA_W-1:0] decay,
                                input logic [CFG_DATA_W-1:0] thr);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idxs [4];
        vals = '{pe, te, decay, thr};
        idxs = '{CFG_PULSE_EN, CFG_TRANSFORM_EN, CFG_DECAY, CFG_THRESHOLD};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out outstanding queries plus a full tick sweep
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic random_items(input int n);
        int               done = 0;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [TIMER_W-1:0] delay;
        while (done < n) begin
            pick = $urandom_range(99);
            op = (pick < 35) ? OP_PULSE : (pick < 55) ? OP_TICK :
                 (pick < 95) ? OP_QUERY : OP_UNUSED;
            // mostly a small cluster of cells so pulses and queries meet
            if ($urandom_range(9) < 7) begin
                row = ROW_W'($urandom_range(1));
                col = COL_W'($urandom_range(3));
            end else begin
                row = ROW_W'($urandom);
                col = COL_W'($urandom);
            end
            delay = ($urandom_range(9) == 0) ? TIMER_W'($urandom) : TIMER_W'($urandom_range(6));
            send_item(op, row, col, delay);
            if (op != OP_UNUSED)
                done++;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] flag_word(input logic bit_val);
        return (CFG_DATA_W'($urandom) & 16'hFFFE) | CFG_DATA_W'(bit_val);
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, pulse enable off so ticks do nothing
        send_item(OP_QUERY, 4'd0, 5'd0, 16'd0);
        send_item(OP_TICK, 4'd0, 5'd0, 16'd0);
        send_item(OP_PULSE, 4'd0, 5'd0, 16'd0);
        drain();
        program_regs(16'd1, 16'd1, 16'd32767, 16'd32768);
        send_item(OP_QUERY, 4'd15, 5'd31, 16'd0);
        send_item(OP_PULSE, 4'd15, 5'd31, 16'd1);
        send_item(OP_PULSE, 4'd7, 5'd16, 16'hFFFF);
        send_item(OP_PULSE, 4'd8, 5'd15, 16'd2);
        send_item(OP_TICK, 4'd0, 5'd0, 16'd0);
        send_item(OP_QUERY, 4'd0, 5'd0, 16'd0);
        send_item(OP_QUERY, 4'd15, 5'd31, 16'd0);
        send_item(OP_QUERY, 4'd1, 5'd1, 16'd0);
        send_item(OP_QUERY, 4'd7, 5'd16, 16'd0);
        send_item(OP_TICK, 4'd0, 5'd0, 16'd0);
        send_item(OP_QUERY, 4'd8, 5'd15, 16'd0);
        send_item(OP_UNUSED, 4'd15, 5'd31, 16'hFFFF);
        drain();
        program_regs(16'd1, 16'd1, 16'd0, 16'd0);
        send_item(OP_TICK, 4'd0, 5'd0, 16'd0);
        send_item(OP_QUERY, 4'd1, 5'd1, 16'd0);
        send_item(OP_TICK, 4'd0, 5'd0, 16'd0);
        send_item(OP_QUERY, 4'd7, 5'd16, 16'd0);
        send_item(OP_QUERY, 4'd15, 5'd31, 16'd0);
        drain();

        program_regs(16'd1, 16'd1, 16'd32767, 16'd0);
        random_items(PHASE_ITEMS);
        drain();

        program_regs(flag_word(1'b1), flag_word(1'b1), CFG_DATA_W'($urandom_range(32767)),
                     CFG_DATA_W'($urandom_range(32768)));
        send_idle_pct = 55;
        random_items(PHASE_ITEMS);
        drain();

        program_regs(16'd1, 16'd0, 16'd0, 16'd32768);
        send_idle_pct = 0;
        stall_pct    <= 55;
        random_items(PHASE_ITEMS);
        drain();

        program_regs(flag_word(1'b0), flag_word(1'b1), CFG_DATA_W'($urandom_range(32767)),
                     16'hFFFF);
        send_idle_pct = 34;
        stall_pct    <= 34;
        random_items(PHASE_ITEMS);
        drain();

        // decay to zero; timers keep counting
        program_regs(16'd1, 16'd1, 16'd0, CFG_DATA_W'($urandom_range(32768)));
        send_idle_pct = 55;
        stall_pct    <= 0;
        random_items(PHASE_ITEMS);
        drain();

        // unused high bit in the decay write
        program_regs(16'd1, 16'd1, CFG_DATA_W'($urandom) | 16'h8000,
                     CFG_DATA_W'($urandom_range(32768)));
        send_idle_pct = 34;
        stall_pct    <= 34;
        random_items(PHASE_ITEMS);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/cpdg_pkg.sv
rtl/cell_pulse_decay_grid.sv
bench/grid_query_checker.sv
bench/cell_pulse_decay_grid_tb.sv
